[hw/rtl/alma_pkg.sv]
// Shared types and constants for the audio level moving average unit.
// Holds field widths, register reset values, register indexes and the sequencer states.
// No dependencies; compile this file first.
package alma_pkg;

  // Field and port widths
  localparam int RAW_W         = 10;
  localparam int GAIN_W        = 7;
  localparam int AMP_W         = 16;
  localparam int BINS_W        = 8;
  localparam int LVL_W         = 8;
  localparam int PROD_W        = AMP_W + BINS_W;
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_TDATA_W   = 24;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int DEPTH_DEFAULT = 32;

  // Register reset values
  localparam logic [GAIN_W-1:0] GAIN_RESET = 7'd1;
  localparam logic [AMP_W-1:0]  AMP_RESET  = 16'd1023;
  localparam logic [BINS_W-1:0] BINS_RESET = 8'd8;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN    = 2'd0,
    CFG_MAX_AMP = 2'd1,
    CFG_BINS    = 2'd2
  } alma_cfg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_GAIN,
    ST_SUM,
    ST_DIV_AVG,
    ST_MUL_LVL,
    ST_DIV_LVL,
    ST_OUT
  } alma_state_t;

endpackage

[hw/rtl/alma_mul.sv]
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Standalone; instantiated by audio_level_moving_average_unit.
module alma_mul #(
  parameter int MC_W = 16,
  parameter int MP_W = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [MC_W-1:0]      mcand,
  input  logic [MP_W-1:0]      mplier,
  output logic [MC_W+MP_W-1:0] product,
  output logic                 done
);

  localparam int P_W   = MC_W + MP_W;
  localparam int CNT_W = $clog2(MP_W + 1);

  logic [P_W-1:0]   acc_r;
  logic [P_W-1:0]   mc_r;
  logic [MP_W-1:0]  mp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MP_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Add the shifted multiplicand for each set multiplier bit
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      mc_r  <= P_W'(mcand);
      mp_r  <= mplier;
    end else if (busy_r) begin
      if (mp_r[0]) begin
        acc_r <= acc_r + mc_r;
      end
      mc_r <= mc_r << 1;
      mp_r <= mp_r >> 1;
    end
  end

  assign product = acc_r;
  assign done    = done_r;

endmodule

[hw/rtl/alma_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Standalone; instantiated by audio_level_moving_average_unit.
module alma_div #(
  parameter int DVD_W = 24,
  parameter int DVS_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] q_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W+1:0] diff;
  logic             ge;

  // Shift in the next dividend bit and trial-subtract the divisor
  assign rem_sh = {rem_r, q_r[DVD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_r};
  assign ge     = ~diff[DVS_W+1];

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient bits replace dividend bits from the bottom of the same register
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule

[hw/rtl/audio_level_moving_average_unit.sv]
// Audio level meter with a boxcar moving average over WINDOW_DEPTH samples. Each request
// carries one converter reading; it is scaled by the gain register, saturated at the
// full-scale register, pushed into a ring of the last WINDOW_DEPTH samples, and one result
// comes back with the truncated window mean and a display level of mean*(bins-1)/full_scale,
// capped at bins-1 (zero when bins is at most one or full scale is zero). The default
// depth is 32. One request is worked on at a time: the next is not accepted until the
// result has been loaded into the output register. Both products come from one shared
// bit-serial multiplier, and both quotients from one shared bit-serial divider (one
// quotient bit a cycle). The ring needs no clearing pass after reset. Configuration is
// to be written only while the unit is idle; the unit itself does not enforce this.
// Depends on alma_pkg, alma_mul and alma_div.
module audio_level_moving_average_unit
  import alma_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: [9:0] raw_sample, [15:10] zero
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: [15:0] average_amplitude, [23:16] display_level
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int PTR_W      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W      = AMP_W + $clog2(WINDOW_DEPTH);
  localparam int DIV_W      = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam int DEPTH_BITS = $clog2(WINDOW_DEPTH + 1);
  localparam int DVS_W      = (DEPTH_BITS > AMP_W) ? DEPTH_BITS : AMP_W;

  alma_state_t       state_r, state_nxt;

  logic [GAIN_W-1:0] gain_r;
  logic [AMP_W-1:0]  max_amp_r;
  logic [BINS_W-1:0] bins_r;

  logic [AMP_W-1:0]  ring_mem [WINDOW_DEPTH];
  logic [AMP_W-1:0]  rd_data_r;
  logic [PTR_W-1:0]  ptr_r;
  logic              full_r;
  logic [SUM_W-1:0]  sum_r, sum_nxt;

  logic [AMP_W-1:0]  scaled_r, scaled_nxt;
  logic [AMP_W-1:0]  avg_r;
  logic [LVL_W-1:0]  level_r, level_nxt;
  logic [AMP_W-1:0]  old_val;
  logic [BINS_W-1:0] top_lvl;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_load;

  logic              mul_start, mul_done;
  logic [AMP_W-1:0]  mul_mc;
  logic [BINS_W-1:0] mul_mp;
  logic [PROD_W-1:0] mul_prod;

  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_dvd, div_q;
  logic [DVS_W-1:0]  div_dvs;

  // Shared serial arithmetic units
  alma_mul #(
    .MC_W (AMP_W),
    .MP_W (BINS_W)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mul_mc),
    .mplier  (mul_mp),
    .product (mul_prod),
    .done    (mul_done)
  );

  alma_div #(
    .DVD_W (DIV_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .done     (div_done)
  );

  // Entries past the pointer before the first wrap were never written and read as zero
  assign old_val    = full_r ? rd_data_r : '0;
  assign sum_nxt    = sum_r - SUM_W'(old_val) + SUM_W'(scaled_r);
  assign scaled_nxt = (mul_prod > PROD_W'(max_amp_r)) ? max_amp_r : mul_prod[AMP_W-1:0];
  assign top_lvl    = bins_r - 1'b1;

  // Level: zero for degenerate settings, capped once the mean reaches full scale
  always_comb begin
    if (bins_r <= BINS_W'(1) || max_amp_r == '0) begin
      level_nxt = '0;
    end else if (avg_r >= max_amp_r) begin
      level_nxt = top_lvl;
    end else begin
      level_nxt = div_q[LVL_W-1:0];
    end
  end

  // Sequencer: next state and unit strobes
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    mul_start = 1'b0;
    mul_mc    = avg_r;
    mul_mp    = top_lvl;
    div_start = 1'b0;
    div_dvd   = DIV_W'(mul_prod);
    div_dvs   = DVS_W'(max_amp_r);
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        mul_mc    = AMP_W'(in_tdata[RAW_W-1:0]);
        mul_mp    = BINS_W'(gain_r);
        if (in_tvalid) begin
          mul_start = 1'b1;
          state_nxt = ST_MUL_GAIN;
        end
      end
      ST_MUL_GAIN: begin
        if (mul_done) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        div_start = 1'b1;
        div_dvd   = DIV_W'(sum_nxt);
        div_dvs   = DVS_W'(WINDOW_DEPTH);
        state_nxt = ST_DIV_AVG;
      end
      ST_DIV_AVG: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_mc    = div_q[AMP_W-1:0];
          state_nxt = ST_MUL_LVL;
        end
      end
      ST_MUL_LVL: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_nxt = ST_DIV_LVL;
        end
      end
      ST_DIV_LVL: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, configuration, window bookkeeping and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gain_r      <= GAIN_RESET;
      max_amp_r   <= AMP_RESET;
      bins_r      <= BINS_RESET;
      ptr_r       <= '0;
      full_r      <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (alma_cfg_t'(cfg_index))
          CFG_GAIN:    gain_r    <= cfg_data[GAIN_W-1:0];
          CFG_MAX_AMP: max_amp_r <= cfg_data[AMP_W-1:0];
          CFG_BINS:    bins_r    <= cfg_data[BINS_W-1:0];
          default: begin
          end
        endcase
      end
      if (state_r == ST_SUM) begin
        sum_r <= sum_nxt;
        if (ptr_r == PTR_W'(WINDOW_DEPTH - 1)) begin
          ptr_r  <= '0;
          full_r <= 1'b1;
        end else begin
          ptr_r <= ptr_r + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Ring memory: read the evicted entry at acceptance, write the new one in the sum step
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      rd_data_r <= ring_mem[ptr_r];
    end
    if (state_r == ST_SUM) begin
      ring_mem[ptr_r] <= scaled_r;
    end
  end

  // Hold intermediate results and the output register
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL_GAIN && mul_done) begin
      scaled_r <= scaled_nxt;
    end
    if (state_r == ST_DIV_AVG && div_done) begin
      avg_r <= div_q[AMP_W-1:0];
    end
    if (state_r == ST_DIV_LVL && div_done) begin
      level_r <= level_nxt;
    end
    if (out_load) begin
      out_data_r <= {level_r, avg_r};
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[hw/rtl/alma_check.sv]
// Port-level checks for audio_level_moving_average_unit, attached by a bind statement.
// Depends on alma_pkg and on the top level's port names.
module alma_check
  import alma_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   cfg_ready
);

  // A stalled result holds its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // One request at a time: input side closes right after an acceptance
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request accepted while busy");

  // Display level never reaches the all-ones code
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:AMP_W] != {LVL_W{1'b1}})
    else $error("display level out of range");

  // Reset drops any pending result
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Configuration port never back-pressures
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port stalled");

endmodule

bind audio_level_moving_average_unit alma_check u_alma_check (.*);

[dv/audio_level_moving_average_unit_tb.sv]
// Self-checking testbench for audio_level_moving_average_unit: streams converter samples,
// predicts the window mean and display level per request, and checks every result.
// Depends on alma_pkg and the unit under test; no files, no arguments.
module audio_level_moving_average_unit_tb;
  import alma_pkg::*;

  localparam int DEPTH           = DEPTH_DEFAULT;
  localparam int QUIET_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 100;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 119;

  // Index with no register behind it; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [AMP_W-1:0] avg;
  } meter_result_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  // Predictor state: configuration copy, sample ring and running sum
  logic [GAIN_W-1:0]  gain_reg;
  logic [AMP_W-1:0]   full_scale_reg;
  logic [BINS_W-1:0]  bins_reg;
  logic [AMP_W-1:0]   meter_ring [DEPTH];
  logic [4:0]         meter_ptr;
  logic [20:0]        meter_sum;

  meter_result_t pending_levels [$];
  meter_result_t next_result;
  int unsigned   error_count  = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   ready_run    = 0;
  bit            gaps_on      = 1'b1;
  bit            stalls_on    = 1'b1;

  audio_level_moving_average_unit #(.WINDOW_DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly back to back, often short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Clear the predictor to its post-reset contents
  function automatic void reset_meter();
    gain_reg       = GAIN_RESET;
    full_scale_reg = AMP_RESET;
    bins_reg       = BINS_RESET;
    for (int i = 0; i < DEPTH; i++) meter_ring[i] = '0;
    meter_ptr = '0;
    meter_sum = '0;
  endfunction

  // Scale, saturate, push into the ring and queue the mean and level it yields
  function automatic void advance_meter(input logic [RAW_W-1:0] raw);
    logic [GAIN_W+RAW_W-1:0] product;
    logic [AMP_W-1:0]        scaled;
    logic [PROD_W-1:0]       level_wide;
    meter_result_t           res;
    product   = raw * gain_reg;
    scaled    = (product > full_scale_reg) ? full_scale_reg : product[AMP_W-1:0];
    meter_sum = meter_sum - meter_ring[meter_ptr] + scaled;
    meter_ring[meter_ptr] = scaled;
    meter_ptr = (meter_ptr == DEPTH - 1) ? '0 : meter_ptr + 1'b1;
    res.avg   = AMP_W'(meter_sum / DEPTH);
    if (bins_reg <= 1 || full_scale_reg == 0) begin
      level_wide = '0;
    end else begin
      level_wide = (PROD_W'(res.avg) * PROD_W'(bins_reg - 1'b1)) / PROD_W'(full_scale_reg);
      if (level_wide > PROD_W'(bins_reg - 1'b1)) level_wide = PROD_W'(bins_reg - 1'b1);
    end
    res.level = level_wide[LVL_W-1:0];
    pending_levels.push_back(res);
  endfunction

  // Send one sample request; keep valid high when the next follows at once
  task automatic send_sample(input logic [RAW_W-1:0] raw);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-RAW_W){1'b0}}, raw};
    do @(posedge clk); while (!in_tready);
    advance_meter(raw);
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write one register and mirror it; valid stays high for back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_GAIN:    gain_reg = value[GAIN_W-1:0];
      CFG_MAX_AMP: full_scale_reg = value;
      CFG_BINS:    bins_reg = value[BINS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    cfg_valid <= 1'b0;
  endtask

  // Drop input valid and hold until every queued result has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  // Randomize result back-pressure: long ready stretches, short and rare long stalls
  always @(posedge clk) begin
    if (ready_run != 0) begin
      ready_run <= ready_run - 1;
    end else if (!stalls_on) begin
      out_tready <= 1'b1;
    end else if (out_tready) begin
      out_tready <= 1'b0;
      ready_run  <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                 : $urandom_range(15, 60);
    end else begin
      out_tready <= 1'b1;
      ready_run  <= $urandom_range(0, 30);
    end
  end

  // Compare each result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_levels.size() == 0) begin
        $error("result with nothing pending: average_amplitude %0d display_level %0d",
               out_tdata[AMP_W-1:0], out_tdata[AMP_W +: LVL_W]);
        error_count++;
      end else begin
        next_result = pending_levels.pop_front();
        if (out_tdata[AMP_W-1:0] !== next_result.avg) begin
          $error("average_amplitude: expected %0d, actual %0d",
                 next_result.avg, out_tdata[AMP_W-1:0]);
          error_count++;
        end
        if (out_tdata[AMP_W +: LVL_W] !== next_result.level) begin
          $error("display_level: expected %0d, actual %0d",
                 next_result.level, out_tdata[AMP_W +: LVL_W]);
          error_count++;
        end
      end
    end
  end

  // End the run when no request moves on any channel for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Window fills from an all-zero ring under reset settings
  task automatic test_reset_defaults();
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd512);
    send_sample(10'd1);
  endtask

  // Gain of 64 with full scale at its largest, then a gain word whose low bits are zero
  task automatic test_gain_extremes();
    wait_idle();
    write_reg(CFG_GAIN, 16'd64);
    write_reg(CFG_MAX_AMP, 16'hFFFF);
    write_reg(CFG_BINS, 16'd255);
    cfg_done();
    send_sample(10'd1023);
    send_sample(10'd1);
    send_sample(10'd1023);
    wait_idle();
    write_reg(CFG_GAIN, 16'hFF80);
    cfg_done();
    send_sample(10'd1023);
  endtask

  // Products above and below the saturation limit
  task automatic test_saturation();
    wait_idle();
    write_reg(CFG_GAIN, 16'd64);
    write_reg(CFG_MAX_AMP, 16'd1000);
    cfg_done();
    send_sample(10'd1023);
    send_sample(10'd20);
    send_sample(10'd15);
  endtask

  // Zero full scale: every sample saturates to zero, level stays zero
  task automatic test_full_scale_zero();
    wait_idle();
    write_reg(CFG_MAX_AMP, 16'd0);
    cfg_done();
    send_sample(10'd1023);
    send_sample(10'd512);
  endtask

  // Zero and one bins, bins word with upper bits set, two bins
  task automatic test_bins_edges();
    wait_idle();
    write_reg(CFG_GAIN, 16'd1);
    write_reg(CFG_MAX_AMP, 16'd1023);
    write_reg(CFG_BINS, 16'd0);
    cfg_done();
    send_sample(10'd1023);
    wait_idle();
    write_reg(CFG_BINS, 16'd1);
    cfg_done();
    send_sample(10'd1023);
    wait_idle();
    write_reg(CFG_BINS, 16'h01FF);
    cfg_done();
    send_sample(10'd1023);
    wait_idle();
    write_reg(CFG_BINS, 16'd2);
    cfg_done();
    send_sample(10'd0);
  endtask

  // Lower full scale under a window of large samples: level caps at bins-1
  task automatic test_above_full_scale();
    wait_idle();
    write_reg(CFG_GAIN, 16'd64);
    write_reg(CFG_MAX_AMP, 16'hFFFF);
    write_reg(CFG_BINS, 16'd255);
    cfg_done();
    repeat (3) send_sample(10'd1023);
    wait_idle();
    write_reg(CFG_MAX_AMP, 16'd100);
    cfg_done();
    send_sample(10'd0);
    send_sample(10'd1);
  endtask

  // Write to the spare index must leave every register alone
  task automatic test_spare_index();
    wait_idle();
    write_reg(CFG_SPARE, 16'hFFFF);
    cfg_done();
    send_sample(10'd700);
    send_sample(10'd3);
  endtask

  // Pick a random setting, extremes included, between phases
  task automatic pick_setting();
    int unsigned r;
    if ($urandom_range(0, 3) != 0) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       write_reg(CFG_GAIN, 16'd0);
        1:       write_reg(CFG_GAIN, 16'd1);
        2:       write_reg(CFG_GAIN, 16'd64);
        3:       write_reg(CFG_GAIN, 16'($urandom_range(0, 65535)));
        default: write_reg(CFG_GAIN, 16'($urandom_range(1, 64)));
      endcase
    end
    if ($urandom_range(0, 3) != 0) begin
      r = $urandom_range(0, 11);
      case (r)
        0:          write_reg(CFG_MAX_AMP, 16'd0);
        1:          write_reg(CFG_MAX_AMP, 16'd1);
        2:          write_reg(CFG_MAX_AMP, 16'hFFFF);
        3, 4, 5, 6: write_reg(CFG_MAX_AMP, 16'($urandom_range(1, 4095)));
        default:    write_reg(CFG_MAX_AMP, 16'($urandom_range(1, 65535)));
      endcase
    end
    if ($urandom_range(0, 3) != 0) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       write_reg(CFG_BINS, 16'd0);
        1:       write_reg(CFG_BINS, 16'd1);
        2:       write_reg(CFG_BINS, 16'd255);
        3:       write_reg(CFG_BINS, 16'($urandom_range(0, 65535)));
        default: write_reg(CFG_BINS, 16'($urandom_range(2, 254)));
      endcase
    end
    if ($urandom_range(0, 7) == 0) write_reg(CFG_SPARE, 16'($urandom_range(0, 65535)));
    cfg_done();
  endtask

  // Phases of random samples, each under a fresh setting and idling mix
  task automatic test_random_phases();
    int unsigned r;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      pick_setting();
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        r = $urandom_range(0, 99);
        if (r < 10)      send_sample(10'd1023);
        else if (r < 18) send_sample(10'd0);
        else if (r < 38) send_sample(10'($urandom_range(0, 31)));
        else             send_sample(10'($urandom_range(0, 1023)));
      end
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    reset_meter();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_gain_extremes();
    test_saturation();
    test_full_scale_zero();
    test_bins_edges();
    test_above_full_scale();
    test_spare_index();
    test_random_phases();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_levels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/alma_pkg.sv
hw/rtl/alma_mul.sv
hw/rtl/alma_div.sv
hw/rtl/audio_level_moving_average_unit.sv
hw/rtl/alma_check.sv
dv/audio_level_moving_average_unit_tb.sv
